[hw/rtl/cbq_pkg.sv]
// ============================================================================
// cbq_pkg: shared types and microcode program of the cascaded biquad low-pass
// Holds the control word layout, step addresses and the program table that
// the sequencer reads one word per cycle.
// ============================================================================
package cbq_pkg;

    // step counter of the microcode program
    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_MUL0  = 4'd1;
    localparam step_t STEP_MUL1  = 4'd2;
    localparam step_t STEP_MUL2  = 4'd3;
    localparam step_t STEP_MUL3  = 4'd4;
    localparam step_t STEP_ACCUM = 4'd5;
    localparam step_t STEP_ROUND = 4'd6;
    localparam step_t STEP_EMIT  = 4'd7;
    localparam step_t STEP_PRIME = 4'd8;

    // multiplier operand pair
    typedef enum logic [1:0] {
        SEL_XSUM = 2'd0,   // (x + x[n-2]) * a0
        SEL_XH0  = 2'd1,   // x[n-1] * 2a0
        SEL_YH0  = 2'd2,   // y[n-1] * b1
        SEL_YH1  = 2'd3    // y[n-2] * b2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        J_NEXT     = 2'd0,  // fall through
        J_DISPATCH = 2'd1,  // wait for an item, branch on func
        J_LOOP     = 2'd2,  // back to target until the last section
        J_WAIT_OUT = 2'd3   // hold until the output register is free
    } jump_t;

    // one word of the program table
    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load_x;
        logic     do_round;
        logic     do_rotate;
        logic     do_prime;
        logic     do_emit;
        logic     ready;
        jump_t    jump;
        step_t    target;
    } ucode_t;

    // datapath controls, already qualified by the jump condition
    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load_x;
        logic     do_round;
        logic     do_rotate;
        logic     do_prime;
        logic     do_emit;
    } dp_ctrl_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w.mul_sel   = SEL_XSUM;
        w.acc_op    = ACC_HOLD;
        w.load_x    = 1'b0;
        w.do_round  = 1'b0;
        w.do_rotate = 1'b0;
        w.do_prime  = 1'b0;
        w.do_emit   = 1'b0;
        w.ready     = 1'b0;
        w.jump      = J_NEXT;
        w.target    = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                w.ready  = 1'b1;
                w.load_x = 1'b1;
                w.jump   = J_DISPATCH;
                w.target = STEP_MUL0;
            end
            STEP_MUL0:
            begin
                w.mul_sel = SEL_XSUM;
            end
            STEP_MUL1:
            begin
                w.mul_sel = SEL_XH0;
                w.acc_op  = ACC_LOAD;
            end
            STEP_MUL2:
            begin
                w.mul_sel = SEL_YH0;
                w.acc_op  = ACC_ADD;
            end
            STEP_MUL3:
            begin
                w.mul_sel = SEL_YH1;
                w.acc_op  = ACC_SUB;
            end
            STEP_ACCUM:
            begin
                w.acc_op = ACC_SUB;
            end
            STEP_ROUND:
            begin
                w.do_round  = 1'b1;
                w.do_rotate = 1'b1;
                w.jump      = J_LOOP;
                w.target    = STEP_MUL0;
            end
            STEP_EMIT:
            begin
                w.do_rotate = 1'b1;
                w.do_emit   = 1'b1;
                w.jump      = J_WAIT_OUT;
                w.target    = STEP_IDLE;
            end
            STEP_PRIME:
            begin
                w.do_prime = 1'b1;
                w.do_emit  = 1'b1;
                w.jump     = J_WAIT_OUT;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w.jump   = J_WAIT_OUT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/cbq_cfg_regs.sv]
// ============================================================================
// cbq_cfg_regs: coefficient registers behind an APB-style port
// Holds a0, b1 and b2; writes complete in the access phase, reads are direct.
// ============================================================================
module cbq_cfg_regs #(
    parameter int COEF_FRAC_BITS = 30,
    parameter int CFG_W          = 32,
    localparam int ALIGN         = (CFG_W == 64) ? 3 : 2,
    localparam int ADDR_W        = ALIGN + 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ADDR_W-1:0]                paddr,
    input  logic [CFG_W-1:0]                 pwdata,
    output logic [CFG_W-1:0]                 prdata,
    output logic                             pready,
    output logic [COEF_FRAC_BITS:0]          coef_a0,
    output logic signed [COEF_FRAC_BITS+1:0] coef_b1,
    output logic signed [COEF_FRAC_BITS+1:0] coef_b2
);

    localparam logic [1:0] REG_A0 = 2'd0;
    localparam logic [1:0] REG_B1 = 2'd1;
    localparam logic [1:0] REG_B2 = 2'd2;

    logic [COEF_FRAC_BITS:0]          coef_a0_reg;
    logic signed [COEF_FRAC_BITS+1:0] coef_b1_reg;
    logic signed [COEF_FRAC_BITS+1:0] coef_b2_reg;
    logic [1:0]                       reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:ALIGN];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a0_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_A0:  coef_a0_reg <= pwdata[COEF_FRAC_BITS:0];
                REG_B1:  coef_b1_reg <= pwdata[COEF_FRAC_BITS+1:0];
                REG_B2:  coef_b2_reg <= pwdata[COEF_FRAC_BITS+1:0];
                default: ;  // unmapped write ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_A0:  prdata = CFG_W'(coef_a0_reg);
            REG_B1:  prdata = CFG_W'(coef_b1_reg);
            REG_B2:  prdata = CFG_W'(coef_b2_reg);
            default: prdata = '0;
        endcase
    end

    assign coef_a0 = coef_a0_reg;
    assign coef_b1 = coef_b1_reg;
    assign coef_b2 = coef_b2_reg;

endmodule

[hw/rtl/cbq_sequencer.sv]
// ============================================================================
// cbq_sequencer: microcode step counter and section loop counter
// Reads one control word per cycle, resolves its jump and drives the datapath.
// ============================================================================
module cbq_sequencer #(
    parameter int STAGES = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              func,
    input  logic              out_free,
    output logic              in_stall,
    output cbq_pkg::dp_ctrl_t ctrl
);

    localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic [STG_W-1:0] STG_LAST = STG_W'(STAGES - 1);

    cbq_pkg::step_t  step_reg;
    cbq_pkg::step_t  step_next;
    logic [STG_W-1:0] stage_reg;
    logic [STG_W-1:0] stage_next;
    cbq_pkg::ucode_t uw;
    logic            go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= cbq_pkg::STEP_IDLE;
            stage_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        uw         = cbq_pkg::ucode_rom(step_reg);
        go         = 1'b1;
        step_next  = step_reg + cbq_pkg::step_t'(1);
        stage_next = stage_reg;
        case (uw.jump)
            cbq_pkg::J_NEXT:
            begin
            end
            cbq_pkg::J_DISPATCH:
            begin
                go         = in_valid;
                stage_next = '0;
                if (!in_valid)
                    step_next = step_reg;
                else if (func)
                    step_next = cbq_pkg::STEP_PRIME;
                else
                    step_next = uw.target;
            end
            cbq_pkg::J_LOOP:
            begin
                if (stage_reg == STG_LAST)
                    stage_next = '0;
                else
                begin
                    stage_next = stage_reg + STG_W'(1);
                    step_next  = uw.target;
                end
            end
            cbq_pkg::J_WAIT_OUT:
            begin
                go        = out_free;
                step_next = out_free ? uw.target : step_reg;
            end
            default:
            begin
                step_next = cbq_pkg::STEP_IDLE;
            end
        endcase

        ctrl.mul_sel   = uw.mul_sel;
        ctrl.acc_op    = uw.acc_op;
        ctrl.load_x    = uw.load_x & go;
        ctrl.do_round  = uw.do_round & go;
        ctrl.do_rotate = uw.do_rotate & go;
        ctrl.do_prime  = uw.do_prime & go;
        ctrl.do_emit   = uw.do_emit & go;
        in_stall       = !uw.ready;
    end

endmodule

[hw/rtl/cbq_datapath.sv]
// ============================================================================
// cbq_datapath: shared multiplier, accumulator, history ring and output
// One multiply per cycle into a product register, accumulate behind it,
// round and saturate, and a ring of history nodes rotated once per section and once on emit.
// ============================================================================
module cbq_datapath #(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 30,
    parameter int STAGES         = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cbq_pkg::dp_ctrl_t                ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
    input  logic [COEF_FRAC_BITS:0]          coef_a0,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_b1,
    input  logic signed [COEF_FRAC_BITS+1:0] coef_b2,
    input  logic                             out_stall,
    output logic                             out_free,
    output logic                             out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]   sample_out
);

    localparam int NODES  = STAGES + 1;
    localparam int MA_W   = SAMPLE_WIDTH + 1;
    localparam int MB_W   = COEF_FRAC_BITS + 3;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // ring position 0 is the current section's input history, 1 its output
    logic signed [SAMPLE_WIDTH-1:0] hist_reg [NODES][2];
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;

    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [ACC_W-1:0]        acc_rnd;
    logic [RND_W-1:0]               rnd;
    logic                           fits;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;

    // operand select
    always_comb
    begin
        case (ctrl.mul_sel)
            cbq_pkg::SEL_XSUM:
            begin
                mul_a = MA_W'(x_reg) + MA_W'(hist_reg[0][1]);
                mul_b = {2'b00, coef_a0};
            end
            cbq_pkg::SEL_XH0:
            begin
                mul_a = MA_W'(hist_reg[0][0]);
                mul_b = {1'b0, coef_a0, 1'b0};
            end
            cbq_pkg::SEL_YH0:
            begin
                mul_a = MA_W'(hist_reg[1][0]);
                mul_b = MB_W'(coef_b1);
            end
            default:
            begin
                mul_a = MA_W'(hist_reg[1][1]);
                mul_b = MB_W'(coef_b2);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (ctrl.acc_op)
            cbq_pkg::ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            cbq_pkg::ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            cbq_pkg::ACC_SUB:  acc_reg <= acc_reg - ACC_W'(prod_reg);
            default:           acc_reg <= acc_reg;
        endcase
    end

    // round half up, drop fraction bits, clamp to sample range
    always_comb
    begin
        acc_rnd = acc_reg + HALF;
        rnd     = acc_rnd[ACC_W-1:COEF_FRAC_BITS];
        fits    = (&rnd[RND_W-1:SAMPLE_WIDTH-1]) | ~(|rnd[RND_W-1:SAMPLE_WIDTH-1]);
        if (fits)
            sat_val = rnd[SAMPLE_WIDTH-1:0];
        else
            sat_val = rnd[RND_W-1] ? SMIN : SMAX;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_x)
            x_reg <= sample_in;
        else if (ctrl.do_round)
            x_reg <= sat_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                hist_reg[n][0] <= '0;
                hist_reg[n][1] <= '0;
            end
        end
        else if (ctrl.do_prime)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                hist_reg[n][0] <= x_reg;
                hist_reg[n][1] <= x_reg;
            end
        end
        else if (ctrl.do_rotate)
        begin
            for (int n = 0; n < NODES - 1; n++)
            begin
                hist_reg[n][0] <= hist_reg[n+1][0];
                hist_reg[n][1] <= hist_reg[n+1][1];
            end
            hist_reg[NODES-1][0] <= x_reg;
            hist_reg[NODES-1][1] <= hist_reg[0][0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.do_emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.do_emit)
            sample_out_reg <= x_reg;
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

[hw/rtl/cascaded_biquad_lowpass_core.sv]
// ============================================================================
// cascaded_biquad_lowpass_core: 2*STAGES-order low-pass from cascaded biquads
// Filters signed Q16.16 samples through STAGES biquad sections that share
// Q2.30 coefficients, or primes all history with a sample and echoes it.
// ============================================================================
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall   func, sample_in
//   out       source     out_valid / out_stall sample_out
//   cfg       sink       psel / penable        paddr, pwdata, pwrite, prdata
//
// a filter item is accepted at the idle step, then runs MUL0 to MUL3, ACCUM and
// ROUND once per section on the single shared multiplier, and EMIT hands the
// result over; a prime item is accepted at idle and handed over from PRIME
// reset clears step counter, history and coefficients; no clearing pass
// in_stall is low only while the sequencer waits at its idle step
// a stalled output holds the sequencer at its last step; the next item is
// still accepted once that result sits in the output register
module cascaded_biquad_lowpass_core #(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 30,
    parameter int STAGES         = 2,
    localparam int CFG_W         = (COEF_FRAC_BITS + 2 > 32) ? 64 : 32,
    localparam int ADDR_W        = (CFG_W == 64) ? 5 : 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    // filtered output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    // coefficient port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [CFG_W-1:0]               pwdata,
    output logic [CFG_W-1:0]               prdata,
    output logic                           pready
);

    logic [COEF_FRAC_BITS:0]          coef_a0;
    logic signed [COEF_FRAC_BITS+1:0] coef_b1;
    logic signed [COEF_FRAC_BITS+1:0] coef_b2;
    logic                             out_free;
    cbq_pkg::dp_ctrl_t                dp_ctrl;

    // coefficients: a0 at 0, b1 at one word, b2 at two words
    cbq_cfg_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .CFG_W          (CFG_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef_a0 (coef_a0),
        .coef_b1 (coef_b1),
        .coef_b2 (coef_b2)
    );

    // program counter walks the microcode table, loops once per section
    cbq_sequencer #(
        .STAGES (STAGES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctrl     (dp_ctrl)
    );

    // shared multiplier, accumulator, history ring and output register
    cbq_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STAGES         (STAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dp_ctrl),
        .sample_in  (sample_in),
        .coef_a0    (coef_a0),
        .coef_b1    (coef_b1),
        .coef_b2    (coef_b2),
        .out_stall  (out_stall),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

`ifndef SYNTHESIS
    // an accepted item leaves the sequencer busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // a result never overwrites one still waiting downstream
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.do_emit |-> out_free)
        else $error("result written over a pending item");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.do_emit |=> out_valid)
        else $error("emitted result not presented");

    // results only appear from work in progress
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output valid rose while idle");
`endif

endmodule

[tb/cascaded_biquad_lowpass_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// cascaded_biquad_lowpass_core_tb: self-checking bench for the biquad low-pass
// Drives filter and prime items through the valid/stall input and loads the
// three shared coefficients over the APB port while the core is idle. Each
// accepted item is run through a bit-exact fixed-point model of the two
// cascaded sections, and each accepted output is compared in order against it.
// ============================================================================
module cascaded_biquad_lowpass_core_tb;

    // register indexes and item operations
    localparam int   REG_A0      = 0;
    localparam int   REG_B1      = 1;
    localparam int   REG_B2      = 2;
    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_PRIME  = 1'b1;

    localparam int SECTIONS         = 2;
    localparam int ITEMS_PER_BLOCK  = 110;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RX_HOLD_CYCLES   = 300;

    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    // butterworth section at a tenth of the sample rate, Q2.30
    localparam int LP_A0 = 72434000;
    localparam int LP_B1 = -1227287000;
    localparam int LP_B2 = 443241000;

    // ------------------------------------------------------------------------
    // expected-sample tracker: own copy of coefficients and history, plus the
    // queue of filtered samples still owed by the core
    // ------------------------------------------------------------------------
    class biquad_tracker;
        logic        [30:0] a0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        // node 0 feeds section 0, node k sits between sections, last is output
        logic signed [31:0] hist [SECTIONS+1][2];
        logic        [31:0] expected_samples [$];
        int                 mismatches;

        function new();
            a0 = '0;
            b1 = '0;
            b2 = '0;
            mismatches = 0;
            foreach (hist[k, j]) hist[k][j] = '0;
        endfunction

        function void set_coef(int idx, logic [31:0] value);
            case (idx)
                REG_A0: a0 = value[30:0];
                REG_B1: b1 = value;
                REG_B2: b2 = value;
                default: ;
            endcase
        endfunction

        // one biquad section: exact sum, round half up, saturate
        function logic signed [31:0] run_section(int k, logic signed [31:0] x);
            logic signed [95:0] xs, xh0, yh0, yh1, ca, cb1, cb2, acc;
            xs  = x;
            xs  = xs + hist[k][1];
            xh0 = hist[k][0];
            yh0 = hist[k+1][0];
            yh1 = hist[k+1][1];
            ca  = {65'd0, a0};
            cb1 = b1;
            cb2 = b2;
            acc = xs * ca + xh0 * (ca <<< 1) - yh0 * cb1 - yh1 * cb2;
            acc = (acc + (96'sd1 <<< 29)) >>> 30;
            hist[k][1] = hist[k][0];
            hist[k][0] = x;
            if (acc > 96'sd2147483647)
                return S_MAX;
            if (acc < -96'sd2147483648)
                return S_MIN;
            return acc[31:0];
        endfunction

        function logic [31:0] filter_sample(logic f, logic signed [31:0] x);
            logic signed [31:0] y;
            y = x;
            if (f == FUNC_PRIME)
            begin
                foreach (hist[k, j]) hist[k][j] = x;
            end
            else
            begin
                for (int k = 0; k < SECTIONS; k++)
                    y = run_section(k, y);
                hist[SECTIONS][1] = hist[SECTIONS][0];
                hist[SECTIONS][0] = y;
            end
            return y;
        endfunction

        function void note_sample(logic f, logic [31:0] x);
            expected_samples.push_back(filter_sample(f, x));
        endfunction

        function void check_sample(logic [31:0] actual);
            logic [31:0] want;
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: no item outstanding, actual %0d", $signed(actual));
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            if (actual !== want)
            begin
                $error("sample_out mismatch: expected %0d actual %0d",
                       $signed(want), $signed(actual));
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        func      = FUNC_FILTER;
    logic [31:0] sample_in = '0;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;

    logic        in_stall;
    logic        out_valid;
    logic [31:0] sample_out;
    logic [31:0] prdata;
    logic        pready;

    // idle rates in percent, set per phase by the main sequence
    int          tx_idle_pct = 11;
    int          rx_idle_pct = 80;
    // long receiver hold-off, requested once by the main sequence
    bit          hold_request = 1'b0;
    int          hold_count   = 0;

    biquad_tracker tracker = new();

    always #4 clk = ~clk;

    cascaded_biquad_lowpass_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off counted here so that
    // the core backs up and stalls its input
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request && hold_count < RX_HOLD_CYCLES)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // handshake monitor: values are read at the edge, before any update
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_sample(sample_out);
            if (in_valid && !in_stall)
                tracker.note_sample(func, sample_in);
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks, each entered and left on a rising edge
    // ------------------------------------------------------------------------

    // offer one item after a random idle gap, return at its accepting edge
    task automatic send_sample(input logic f, input logic [31:0] s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        sample_in <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering, wait for every owed sample, then let the core settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write, setup then access phase; the model follows at the same time
    task automatic write_coef(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_coef(idx, value);
    endtask

    task automatic write_coefs(input logic [31:0] a0, input logic [31:0] b1,
                               input logic [31:0] b2);
        write_coef(REG_A0, a0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
    endtask

    // coefficient sets for the random blocks: stable low-pass, raw words,
    // and corners of the register ranges
    task automatic load_coef_set(input int kind);
        logic [31:0] a0, b1, b2;
        case (kind)
            0:
            begin
                a0 = $urandom_range(1 << 27, 1 << 20);
                b1 = LP_B1 + int'($urandom_range(1 << 25)) - (1 << 24);
                b2 = LP_B2 + int'($urandom_range(1 << 25)) - (1 << 24);
            end
            1:
            begin
                a0 = $urandom;
                b1 = $urandom;
                b2 = $urandom;
            end
            default:
            begin
                case ($urandom_range(2))
                    0: a0 = 32'd0;
                    1: a0 = 32'h4000_0000;
                    default: a0 = 32'h7FFF_FFFF;
                endcase
                b1 = $urandom_range(1) ? S_MAX : S_MIN;
                case ($urandom_range(2))
                    0: b2 = 32'hC000_0000;
                    1: b2 = 32'h4000_0000;
                    default: b2 = S_MIN;
                endcase
            end
        endcase
        write_coefs(a0, b1, b2);
    endtask

    // mix of full-range, small, mid-size and corner samples
    function automatic logic [31:0] random_sample();
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range((1 << 21) - 1)) - (1 << 20);
            2: return int'($urandom_range((1 << 29) - 1)) - (1 << 28);
            default:
            begin
                case ($urandom_range(4))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return 32'd0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'd1;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset: filter gives zero, prime echoes
        send_sample(FUNC_FILTER, S_MAX);
        send_sample(FUNC_PRIME, S_MIN);
        send_sample(FUNC_FILTER, S_MIN);
        drain_results();

        // a0 of one half: exact rounding ties on +1 and -1 lsb
        write_coefs(32'h2000_0000, 32'd0, 32'd0);
        send_sample(FUNC_PRIME, 32'd0);
        send_sample(FUNC_FILTER, 32'd1);
        send_sample(FUNC_PRIME, 32'd0);
        send_sample(FUNC_FILTER, 32'hFFFF_FFFF);
        drain_results();

        // realistic low-pass: full-scale steps and priming at both rails
        write_coefs(LP_A0, LP_B1, LP_B2);
        send_sample(FUNC_PRIME, S_MAX);
        repeat (3) send_sample(FUNC_FILTER, S_MAX);
        repeat (3) send_sample(FUNC_FILTER, S_MIN);
        send_sample(FUNC_PRIME, S_MIN);
        send_sample(FUNC_FILTER, S_MAX);
        drain_results();

        // coefficients beyond their stated range drive both sections to saturate
        write_coefs(32'h7FFF_FFFF, S_MIN, S_MIN);
        send_sample(FUNC_PRIME, 32'd0);
        send_sample(FUNC_FILTER, S_MAX);
        send_sample(FUNC_FILTER, S_MIN);
        send_sample(FUNC_FILTER, S_MAX);
        send_sample(FUNC_FILTER, S_MIN);
        send_sample(FUNC_FILTER, 32'd0);
        drain_results();

        write_coefs(32'h4000_0000, S_MAX, 32'h4000_0000);
        send_sample(FUNC_FILTER, 32'h0001_0000);
        send_sample(FUNC_FILTER, 32'hFFFF_0000);
        send_sample(FUNC_PRIME, 32'h1234_5678);
        drain_results();

        // random part: three idle profiles, three coefficient sets each
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 11;
                    rx_idle_pct = 80;
                end
                1:
                begin
                    tx_idle_pct = 80;
                    rx_idle_pct = 11;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                load_coef_set(blk);
                // one long receiver hold-off while items keep coming
                if (phase == 0 && blk == 1)
                    hold_request = 1'b1;
                repeat (ITEMS_PER_BLOCK)
                begin
                    send_sample(($urandom_range(99) < 5) ? FUNC_PRIME : FUNC_FILTER,
                                random_sample());
                end
                // sender pauses until the core has handed back everything
                drain_results();
            end
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("cascaded_biquad_lowpass_core_tb passed");
        else
            $display("cascaded_biquad_lowpass_core_tb failed");
        $finish;
    end

    // run limit, far beyond the slowest passing run
    initial
    begin
        #5_000_000;
        $display("cascaded_biquad_lowpass_core_tb failed");
        $finish;
    end

endmodule
